// ===== rtl/usbps2_pkg.sv =====
package usbps2_pkg;

  localparam int SLOTS    = 14;
  localparam int MODS     = 8;
  localparam int KEYS     = 6;
  localparam int MAX_OUT  = 50;
  localparam int CNT_W    = $clog2(MAX_OUT + 1);
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int POSITIONS = 5;
  localparam int POS_W    = $clog2(POSITIONS);

  localparam logic [7:0] BYTE_BREAK  = 8'hF0;
  localparam logic [7:0] BYTE_EXT    = 8'hE0;
  localparam logic [7:0] BYTE_FAIL   = 8'hFC;
  localparam logic [7:0] CODE_F7     = 8'h83;
  localparam logic [7:0] CODE_EXT    = 8'h80;
  localparam logic [7:0] CODE_NONE   = 8'h7F;
  localparam logic [7:0] MOD_BASE    = 8'hE0;

  localparam logic OP_REPORT = 1'b0;
  localparam logic OP_WRITE  = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [7:0] modifier_bits;
    logic [7:0] key_code_1;
    logic [7:0] key_code_2;
    logic [7:0] key_code_3;
    logic [7:0] key_code_4;
    logic [7:0] key_code_5;
    logic [7:0] key_code_6;
    logic [7:0] table_index;
    logic [7:0] table_value;
  } rpt_t;

  typedef struct packed {
    logic [7:0] ps2_byte;
    logic       last_byte;
    logic       make_seen;
    logic [7:0] latest_make_first;
    logic [7:0] latest_make_second;
  } ps2_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_GEN,
    ST_FLUSH
  } state_t;

  // Byte positions 0..2 hold the break sequence, 3..4 the make sequence.
  typedef struct packed {
    logic [POSITIONS-1:0]      vld;
    logic [POSITIONS-1:0][7:0] b;
  } slot_bytes_t;

  typedef struct packed {
    logic       wr_en;
    logic [7:0] wr_addr;
    logic [7:0] wr_data;
  } tbl_wr_t;

  localparam logic [7:0] TABLE_INIT [256] = '{
    'h7f, 'h00, 'h80, 'h7f, 'h1c, 'h32, 'h21, 'h23, 'h24, 'h2b, 'h34, 'h33, 'h43, 'h3b, 'h42, 'h4b,
    'h3a, 'h31, 'h44, 'h4d, 'h15, 'h2d, 'h1b, 'h2c, 'h3c, 'h2a, 'h1d, 'h22, 'h35, 'h1a, 'h16, 'h1e,
    'h26, 'h25, 'h2e, 'h36, 'h3d, 'h3e, 'h46, 'h45, 'h5a, 'h76, 'h66, 'h0d, 'h29, 'h4e, 'h55, 'h54,
    'h5b, 'h5d, 'h5d, 'h4c, 'h52, 'h0e, 'h41, 'h49, 'h4a, 'h58, 'h05, 'h06, 'h04, 'h0c, 'h03, 'h0b,
    'h83, 'h0a, 'h01, 'h09, 'h78, 'h07, 'hfc, 'h7e, 'hf7, 'hf0, 'hec, 'hfd, 'hf1, 'he9, 'hfa, 'hf4,
    'heb, 'hf2, 'hf5, 'h77, 'hca, 'h7c, 'h7b, 'h79, 'h1a, 'h69, 'h72, 'h7a, 'h6b, 'h73, 'h74, 'h6c,
    'h75, 'h7d, 'h70, 'h71, 'h61, 'haf, 'h7f, 'h0f, 'h2f, 'h37, 'h3f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f,
    'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f,
    'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h6d, 'h7f, 'h51, 'h13, 'h6a, 'h64, 'h67, 'h27, 'h7f, 'h7f, 'h7f,
    'h7f, 'h7f, 'h63, 'h62, 'h5f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f,
    'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f,
    'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f,
    'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f,
    'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f,
    'h14, 'h12, 'h11, 'h9f, 'h94, 'h59, 'h91, 'ha7, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f,
    'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f, 'h7f
  };

  // Build the break and make byte sequences of one slot from its table entries.
  function automatic slot_bytes_t gen_bytes(input logic [7:0] o, input logic present,
                                            input logic [7:0] n);
    slot_bytes_t r;
    r = '0;
    if (!present) begin
      if ((o > 8'h00 && o < CODE_NONE) || o == CODE_F7) begin
        r.vld[1] = 1'b1;
        r.b[1]   = BYTE_BREAK;
        r.vld[2] = 1'b1;
        r.b[2]   = o;
      end else if (o > CODE_EXT) begin
        r.vld[0] = 1'b1;
        r.b[0]   = BYTE_EXT;
        r.vld[1] = 1'b1;
        r.b[1]   = BYTE_BREAK;
        r.vld[2] = 1'b1;
        r.b[2]   = o - CODE_EXT;
      end
    end
    if (n > CODE_EXT && n != CODE_F7) begin
      r.vld[3] = 1'b1;
      r.b[3]   = BYTE_EXT;
      r.vld[4] = 1'b1;
      r.b[4]   = n - CODE_EXT;
    end else if (n == CODE_EXT) begin
      r.vld[4] = 1'b1;
      r.b[4]   = BYTE_FAIL;
    end else if (n < CODE_NONE || n == CODE_F7) begin
      r.vld[4] = 1'b1;
      r.b[4]   = n;
    end
    return r;
  endfunction

endpackage

// ===== rtl/usb_report_to_ps2_scan_codes.sv =====
// Channel   Direction  Handshake             Payload
// rpt       in         rpt_valid/rpt_ready   rpt_t: report or table write
// ps2       out        ps2_valid/ps2_ready   ps2_t: one PS/2 byte
//
// A table write is taken while idle. A report walks all 14 slots in turn:
// one table read state and five byte positions for each slot.
// One byte is held back so the final byte of a report can carry last_byte.
// Reset restores the preloaded table and clears all slot history.
// A stalled ps2 output stalls byte generation; rpt_ready is high only when idle.
module usb_report_to_ps2_scan_codes
  import usbps2_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic rpt_valid,
  output logic rpt_ready,
  input  rpt_t rpt,
  output logic ps2_valid,
  input  logic ps2_ready,
  output ps2_t ps2
);

  state_t state, state_next;

  logic [SLOTS-1:0][7:0] prev;
  logic [SLOTS-1:0][7:0] now_codes;
  logic [SLOTS-1:0][7:0] old_sh;
  logic [SLOTS-1:0][7:0] new_sh;
  logic [SLOTS-1:0]      pres_mask;
  logic [SLOTS-1:0]      pres_sh;
  logic [SLOT_W-1:0]     slot;
  logic [POS_W-1:0]      pos;
  logic [CNT_W-1:0]      cnt;
  logic                  made;
  logic [7:0]            latest_first;
  logic [7:0]            latest_second;
  logic                  pend_v;
  logic [7:0]            pend;

  logic [7:0]  tbl_old, tbl_new;
  tbl_wr_t     tbl_wr;
  slot_bytes_t cur;
  logic        accept, out_free, byte_here, proceed, load_out, flush_done;

  // Slot codes of the incoming report.
  always_comb begin
    for (int i = 0; i < MODS; i++) begin
      now_codes[i] = rpt.modifier_bits[i] ? (MOD_BASE + 8'(i)) : 8'h00;
    end
    now_codes[MODS+0] = rpt.key_code_1;
    now_codes[MODS+1] = rpt.key_code_2;
    now_codes[MODS+2] = rpt.key_code_3;
    now_codes[MODS+3] = rpt.key_code_4;
    now_codes[MODS+4] = rpt.key_code_5;
    now_codes[MODS+5] = rpt.key_code_6;
  end

  // One presence lane per slot; modifier lanes compare against their own code only.
  for (genvar g = 0; g < SLOTS; g++) begin : g_lane
    logic [KEYS-1:0][7:0] cand;
    if (g < MODS) begin : g_mod
      assign cand = {KEYS{now_codes[g]}};
    end else begin : g_key
      assign cand = now_codes[SLOTS-1:MODS];
    end
    usbps2_lane u_lane (
      .old_code (prev[g]),
      .cand     (cand),
      .present  (pres_mask[g])
    );
  end

  assign tbl_wr.wr_en   = accept && rpt.operation == OP_WRITE;
  assign tbl_wr.wr_addr = rpt.table_index;
  assign tbl_wr.wr_data = rpt.table_value;

  usbps2_table u_table (
    .clk       (clk),
    .rst       (rst),
    .wr        (tbl_wr),
    .rd_addr_a (old_sh[0]),
    .rd_addr_b (new_sh[0]),
    .rd_data_a (tbl_old),
    .rd_data_b (tbl_new)
  );

  // Control outputs of the sequencer.
  always_comb begin
    rpt_ready  = state == ST_IDLE;
    accept     = rpt_valid && rpt_ready;
    out_free   = !ps2_valid || ps2_ready;
    cur        = gen_bytes(tbl_old, pres_sh[0], tbl_new);
    byte_here  = cur.vld[pos] && cnt < CNT_W'(MAX_OUT);
    proceed    = 1'b0;
    load_out   = 1'b0;
    flush_done = 1'b0;
    case (state)
      ST_GEN: begin
        proceed  = !(byte_here && pend_v && !out_free);
        load_out = byte_here && pend_v && out_free;
      end
      ST_FLUSH: begin
        load_out   = pend_v && out_free;
        flush_done = !pend_v || out_free;
      end
      default: ;
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept && rpt.operation == OP_REPORT) state_next = ST_READ;
      ST_READ:  state_next = ST_GEN;
      ST_GEN: begin
        if (proceed && pos == POS_W'(POSITIONS - 1)) begin
          state_next = (slot == SLOT_W'(SLOTS - 1)) ? ST_FLUSH : ST_READ;
        end
      end
      ST_FLUSH: if (flush_done) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Slot history, shift lines and byte generation.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev          <= '0;
      slot          <= '0;
      pos           <= '0;
      cnt           <= '0;
      made          <= 1'b0;
      latest_first  <= 8'h00;
      latest_second <= 8'h00;
      pend_v        <= 1'b0;
    end else begin
      if (accept && rpt.operation == OP_REPORT) begin
        old_sh  <= prev;
        new_sh  <= now_codes;
        pres_sh <= pres_mask;
        prev    <= now_codes;
        slot    <= '0;
        pos     <= '0;
        cnt     <= '0;
        made    <= 1'b0;
      end
      if (state == ST_GEN && proceed) begin
        if (cur.vld[pos] && pos >= POS_W'(3)) begin
          made          <= 1'b1;
          latest_first  <= cur.vld[3] ? cur.b[3] : cur.b[4];
          latest_second <= cur.b[4];
        end
        if (byte_here) begin
          pend   <= cur.b[pos];
          pend_v <= 1'b1;
          cnt    <= cnt + CNT_W'(1);
        end
        if (pos == POS_W'(POSITIONS - 1)) begin
          pos     <= '0;
          slot    <= slot + SLOT_W'(1);
          old_sh  <= {8'h00, old_sh[SLOTS-1:1]};
          new_sh  <= {8'h00, new_sh[SLOTS-1:1]};
          pres_sh <= {1'b0, pres_sh[SLOTS-1:1]};
        end else begin
          pos <= pos + POS_W'(1);
        end
      end
      if (state == ST_FLUSH && load_out) pend_v <= 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ps2_valid <= 1'b0;
    end else begin
      if (ps2_valid && ps2_ready) ps2_valid <= 1'b0;
      if (load_out) ps2_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      ps2.ps2_byte <= pend;
      if (state == ST_FLUSH) begin
        ps2.last_byte          <= 1'b1;
        ps2.make_seen          <= made;
        ps2.latest_make_first  <= latest_first;
        ps2.latest_make_second <= latest_second;
      end else begin
        ps2.last_byte          <= 1'b0;
        ps2.make_seen          <= 1'b0;
        ps2.latest_make_first  <= 8'h00;
        ps2.latest_make_second <= 8'h00;
      end
    end
  end

  a_cnt_cap: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_OUT)) else $error("byte count beyond cap");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !pend_v) else $error("held byte left when idle");

  a_flush_last: assert property (@(posedge clk) disable iff (rst)
    $fell(pend_v) |-> ps2_valid && ps2.last_byte)
    else $error("held byte dropped without last-byte transfer");

endmodule

// ===== rtl/usbps2_lane.sv =====
module usbps2_lane
  import usbps2_pkg::*;
(
  input  logic [7:0]            old_code,
  input  logic [KEYS-1:0][7:0]  cand,
  output logic                  present
);

  // The old code stays present if any candidate of the new report matches it.
  always_comb begin
    present = 1'b0;
    for (int j = 0; j < KEYS; j++) begin
      if (cand[j] == old_code) present = 1'b1;
    end
  end

endmodule

// ===== rtl/usbps2_table.sv =====
module usbps2_table
  import usbps2_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  tbl_wr_t    wr,
  input  logic [7:0] rd_addr_a,
  input  logic [7:0] rd_addr_b,
  output logic [7:0] rd_data_a,
  output logic [7:0] rd_data_b
);

  logic [7:0] mem [256];
  logic [255:0] written;

  // Entries not yet written read as the preloaded contents.
  always_ff @(posedge clk) begin
    if (wr.wr_en) mem[wr.wr_addr] <= wr.wr_data;
    rd_data_a <= written[rd_addr_a] ? mem[rd_addr_a] : TABLE_INIT[rd_addr_a];
    rd_data_b <= written[rd_addr_b] ? mem[rd_addr_b] : TABLE_INIT[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr.wr_en) begin
      written[wr.wr_addr] <= 1'b1;
    end
  end

endmodule

// ===== bench/usb_report_to_ps2_scan_codes_tb.sv =====
module usb_report_to_ps2_scan_codes_tb;
  import usbps2_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic rpt_valid = 1'b0;
  logic rpt_ready;
  rpt_t rpt = '0;
  logic ps2_valid;
  logic ps2_ready = 1'b0;
  ps2_t ps2;

  // Shadow state of the translator.
  logic [7:0] shadow_slots [SLOTS];
  logic [7:0] shadow_table [256];
  logic [7:0] shadow_latest [2];
  ps2_t scan_bytes_due [$];
  ps2_t report_bytes [$];

  int errors = 0;
  int reports_sent = 0;
  int writes_sent = 0;
  int bytes_checked = 0;
  int long_hold = 0;

  usb_report_to_ps2_scan_codes uut (
    .clk(clk), .rst(rst),
    .rpt_valid(rpt_valid), .rpt_ready(rpt_ready), .rpt(rpt),
    .ps2_valid(ps2_valid), .ps2_ready(ps2_ready), .ps2(ps2)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

  // Add one byte for the current report; bytes past the cap are dropped.
  function automatic void add_byte(input logic [7:0] b);
    ps2_t r;
    r = '0;
    r.ps2_byte = b;
    if (report_bytes.size() < MAX_OUT) report_bytes.push_back(r);
  endfunction

  // Work out the PS/2 bytes that one transfer causes.
  function automatic void translate_item(input rpt_t it);
    logic [7:0] cur [SLOTS];
    logic held [SLOTS];
    logic [7:0] n;
    logic made;
    ps2_t r;
    made = 1'b0;
    report_bytes.delete();
    if (it.operation == OP_WRITE) begin
      shadow_table[it.table_index] = it.table_value;
      return;
    end
    for (int i = 0; i < MODS; i++)
      cur[i] = it.modifier_bits[i] ? MOD_BASE + 8'(i) : 8'h00;
    cur[8] = it.key_code_1; cur[9] = it.key_code_2; cur[10] = it.key_code_3;
    cur[11] = it.key_code_4; cur[12] = it.key_code_5; cur[13] = it.key_code_6;
    for (int i = 0; i < SLOTS; i++) begin
      if (i < MODS) held[i] = (cur[i] == shadow_slots[i]);
      else begin
        held[i] = 1'b0;
        for (int j = MODS; j < SLOTS; j++)
          if (cur[j] == shadow_slots[i]) held[i] = 1'b1;
      end
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (!held[i]) begin
        n = shadow_table[shadow_slots[i]];
        if ((n > 8'h00 && n < CODE_NONE) || n == CODE_F7) begin
          add_byte(BYTE_BREAK); add_byte(n);
        end else if (n > CODE_EXT) begin
          add_byte(BYTE_EXT); add_byte(BYTE_BREAK); add_byte(n - CODE_EXT);
        end
      end
      n = shadow_table[cur[i]];
      if (n > CODE_EXT && n != CODE_F7) begin
        add_byte(BYTE_EXT); add_byte(n - CODE_EXT);
        shadow_latest[0] = BYTE_EXT; shadow_latest[1] = n - CODE_EXT; made = 1'b1;
      end else if (n == CODE_EXT) begin
        add_byte(BYTE_FAIL);
        shadow_latest[0] = BYTE_FAIL; shadow_latest[1] = BYTE_FAIL; made = 1'b1;
      end else if (n < CODE_NONE || n == CODE_F7) begin
        add_byte(n);
        shadow_latest[0] = n; shadow_latest[1] = n; made = 1'b1;
      end
      shadow_slots[i] = cur[i];
    end
    if (report_bytes.size() > 0) begin
      r = report_bytes.pop_back();
      r.last_byte = 1'b1;
      r.make_seen = made;
      r.latest_make_first = shadow_latest[0];
      r.latest_make_second = shadow_latest[1];
      report_bytes.push_back(r);
    end
    foreach (report_bytes[k]) scan_bytes_due.push_back(report_bytes[k]);
  endfunction

  // Send one item after a random gap and predict its bytes on the transfer.
  // With no gap, valid stays high straight into the next item.
  task automatic send_item(input rpt_t it);
    int gap;
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      rpt_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rpt <= it;
    rpt_valid <= 1'b1;
    @(posedge clk);
    while (!rpt_ready) @(posedge clk);
    translate_item(it);
    if (it.operation == OP_WRITE) writes_sent++;
    else reports_sent++;
  endtask

  function automatic rpt_t make_report(input logic [7:0] m, input logic [7:0] k1,
      input logic [7:0] k2, input logic [7:0] k3, input logic [7:0] k4,
      input logic [7:0] k5, input logic [7:0] k6);
    rpt_t it;
    it = '0;
    it.operation = OP_REPORT;
    it.modifier_bits = m;
    it.key_code_1 = k1; it.key_code_2 = k2; it.key_code_3 = k3;
    it.key_code_4 = k4; it.key_code_5 = k5; it.key_code_6 = k6;
    it.table_index = 8'($urandom);
    it.table_value = 8'($urandom);
    return it;
  endfunction

  function automatic rpt_t make_write(input logic [7:0] idx, input logic [7:0] val);
    rpt_t it;
    it = make_report(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom), 8'($urandom), 8'($urandom));
    it.operation = OP_WRITE;
    it.table_index = idx;
    it.table_value = val;
    return it;
  endfunction

  // Pick a usage code: mostly mapped keys, sometimes anything.
  function automatic logic [7:0] pick_key();
    case ($urandom_range(0, 9))
      0, 1: return 8'h00;
      2: return 8'($urandom);
      3: return 8'($urandom_range(8'h60, 8'h9f));
      default: return 8'($urandom_range(8'h01, 8'h53));
    endcase
  endfunction

  function automatic rpt_t random_report();
    return make_report(8'($urandom), pick_key(), pick_key(), pick_key(),
                       pick_key(), pick_key(), pick_key());
  endfunction

  task automatic wait_drained();
    rpt_valid <= 1'b0;
    while (scan_bytes_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // Extremes, release forms, overrun, POST fail, prefixed codes and modifiers.
  task automatic test_directed();
    send_item(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(make_report(8'hFF, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
    send_item(make_report(8'hFF, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
    send_item(make_report(8'h00, 8'h01, 8'h02, 8'h40, 8'h48, 8'h49, 8'hFF));
    send_item(make_report(8'hAA, 8'h4F, 8'h54, 8'h58, 8'h65, 8'h46, 8'h68));
    send_item(make_report(8'h55, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(make_report(8'h00, 8'h03, 8'h03, 8'h04, 8'h04, 8'h00, 8'h00));
    send_item(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    wait_drained();
    // Rewritten table puts prefixed codes on the modifiers and code 0x00, so the output reaches the byte cap.
    send_item(make_write(8'h00, 8'hFF));
    send_item(make_write(8'hFF, 8'h80));
    send_item(make_write(8'h10, 8'h83));
    send_item(make_write(8'h11, 8'h7F));
    for (int i = 0; i < 8; i++) send_item(make_write(MOD_BASE + 8'(i), 8'hC1 + 8'(i)));
    send_item(make_report(8'hFF, 8'h10, 8'h11, 8'hFF, 8'h30, 8'h31, 8'h32));
    send_item(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(make_report(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    wait_drained();
  endtask

  // Random reports and occasional table writes.
  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 14) == 0)
        send_item(make_write(8'($urandom), 8'($urandom)));
      else if ($urandom_range(0, 3) == 0)
        send_item(make_report(8'($urandom), 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                              8'h00));
      else
        send_item(random_report());
      if (i == count / 2) wait_drained();
    end
  endtask

  // The receiver stops for a long stretch while reports keep coming.
  task automatic test_backpressure();
    long_hold = 400;
    for (int i = 0; i < 8; i++) send_item(random_report());
    wait_drained();
  endtask

  // Receiver: inserts random ready gaps between bytes, plus a long hold when requested.
  initial begin
    int rx_wait;
    rx_wait = $urandom_range(0, 5);
    ps2_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold > 0) begin
        ps2_ready <= 1'b0;
        long_hold--;
      end else if (ps2_valid && ps2_ready) begin
        rx_wait = $urandom_range(0, 5);
        ps2_ready <= (rx_wait == 0);
      end else if (rx_wait > 0) begin
        rx_wait--;
        ps2_ready <= (rx_wait == 0);
      end else begin
        ps2_ready <= 1'b1;
      end
    end
  end

  // Check each byte transfer against the oldest expected byte.
  always @(posedge clk) begin
    ps2_t want;
    if (!rst && ps2_valid && ps2_ready) begin
      bytes_checked++;
      if (scan_bytes_due.size() == 0) begin
        $display("%0t: unexpected byte, expected none, actual %h", $realtime, ps2);
        errors++;
      end else begin
        want = scan_bytes_due.pop_front();
        if (want.ps2_byte !== ps2.ps2_byte) begin
          $display("%0t: ps2_byte expected %h actual %h", $realtime,
                   want.ps2_byte, ps2.ps2_byte);
          errors++;
        end
        if (want.last_byte !== ps2.last_byte) begin
          $display("%0t: last_byte expected %b actual %b", $realtime,
                   want.last_byte, ps2.last_byte);
          errors++;
        end
        if (want.make_seen !== ps2.make_seen) begin
          $display("%0t: make_seen expected %b actual %b", $realtime,
                   want.make_seen, ps2.make_seen);
          errors++;
        end
        if (want.latest_make_first !== ps2.latest_make_first) begin
          $display("%0t: latest_make_first expected %h actual %h", $realtime,
                   want.latest_make_first, ps2.latest_make_first);
          errors++;
        end
        if (want.latest_make_second !== ps2.latest_make_second) begin
          $display("%0t: latest_make_second expected %h actual %h", $realtime,
                   want.latest_make_second, ps2.latest_make_second);
          errors++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) shadow_slots[i] = 8'h00;
    for (int i = 0; i < 256; i++) shadow_table[i] = TABLE_INIT[i];
    shadow_latest[0] = 8'h00;
    shadow_latest[1] = 8'h00;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(400);
    wait_drained();
    if (scan_bytes_due.size() != 0) begin
      $display("%0t: %0d expected bytes never arrived", $realtime, scan_bytes_due.size());
      errors++;
    end
    $display("Covered %0d reports and %0d table writes, %0d PS/2 bytes checked,",
             reports_sent, writes_sent, bytes_checked);
    $display("including the output cap, a long receiver hold and table rewrites.");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/usbps2_pkg.sv
rtl/usbps2_lane.sv
rtl/usbps2_table.sv
rtl/usb_report_to_ps2_scan_codes.sv
bench/usb_report_to_ps2_scan_codes_tb.sv
